FILE: design/gtin_pkg.sv
// Package with the status and kind codes and the mod-10 helpers for the GTIN checker.
package gtin_pkg;

    typedef enum logic [1:0] {
        STATUS_CHECKED  = 2'd0,
        STATUS_BAD_LEN  = 2'd1,
        STATUS_BAD_CHAR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_LEN8   = 3'd1,
        KIND_LEN12  = 3'd2,
        KIND_LEN13  = 3'd3,
        KIND_LEN14  = 3'd4,
        KIND_LEN17  = 3'd5,
        KIND_LEN18  = 3'd6
    } kind_t;

    localparam logic [4:0] COUNT_MAX  = 5'd31;
    localparam logic [3:0] ASCII_HIGH = 4'h3;
    localparam logic [3:0] MOD10      = 4'd10;

    // Sum of two decimal digits, reduced mod 10.
    function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, MOD10})
            t = t - {1'b0, MOD10};
        return t[3:0];
    endfunction

    // 9 * a mod 10 is the ten's complement of a.
    function automatic logic [3:0] times9_mod10(input logic [3:0] a);
        return (a == 4'd0) ? 4'd0 : MOD10 - a;
    endfunction

    function automatic logic [3:0] times7_mod10(input logic [3:0] a);
        logic [3:0] r;
        case (a)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd7;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd1;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd5;
            4'd6:    r = 4'd2;
            4'd7:    r = 4'd9;
            4'd8:    r = 4'd6;
            4'd9:    r = 4'd3;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic kind_t length_kind(input logic [5:0] len);
        kind_t k;
        case (len)
            6'd8:    k = KIND_LEN8;
            6'd12:   k = KIND_LEN12;
            6'd13:   k = KIND_LEN13;
            6'd14:   k = KIND_LEN14;
            6'd17:   k = KIND_LEN17;
            6'd18:   k = KIND_LEN18;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

FILE: design/gtin_check_digit_checker_top.sv
// Top level of the GTIN mod-10 check-digit checker.
// The block takes one ASCII character per beat, most significant first, with last_char
// marking the check character, and gives one result beat per number: a status, the
// length kind, the computed check digit and a mismatch flag. A character is taken in
// every cycle; each beat passes an input register and then the running-sum update,
// and a check character's verdict is then written to the result register. The only
// thing that holds input back is a result register that is still full and stalled
// when a check character needs it.
module gtin_check_digit_checker_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] status,
    output logic [2:0] kind,
    output logic [3:0] expected_digit,
    output logic       mismatch
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_code_reg;
    logic       in_last_reg;

    // Running state of the current number
    logic [4:0] count_reg, count_next;
    logic [3:0] even_sum_reg, even_sum_next;
    logic [3:0] odd_sum_reg, odd_sum_next;
    logic       bad_reg, bad_next;

    // Result register
    logic             out_valid_reg;
    gtin_pkg::status_t out_status_reg, out_status_next;
    gtin_pkg::kind_t   out_kind_reg, out_kind_next;
    logic [3:0]       out_digit_reg, out_digit_next;
    logic             out_mis_reg, out_mis_next;

    logic       out_free;
    logic       work_fire;
    logic       in_take;
    logic       is_digit;
    logic [3:0] digit;
    logic [5:0] total_len;
    gtin_pkg::kind_t len_kind;
    logic [3:0] w9_src, w7_src;
    logic [3:0] expect_val;

    assign out_free   = !out_valid_reg || !result_stall;
    assign work_fire  = in_valid_reg && (!in_last_reg || out_free);
    assign char_stall = in_valid_reg && !work_fire;
    assign in_take    = char_valid && !char_stall;

    assign is_digit  = (in_code_reg[7:4] == gtin_pkg::ASCII_HIGH) && (in_code_reg[3:0] < 4'd10);
    assign digit     = in_code_reg[3:0];
    assign total_len = {1'b0, count_reg} + 6'd1;
    assign len_kind  = (count_reg == gtin_pkg::COUNT_MAX) ? gtin_pkg::KIND_NONE
                                                          : gtin_pkg::length_kind(total_len);

    // Weight 9 falls on digits an even distance from the check character.
    assign w9_src     = total_len[0] ? even_sum_reg : odd_sum_reg;
    assign w7_src     = total_len[0] ? odd_sum_reg : even_sum_reg;
    assign expect_val = gtin_pkg::add_mod10(gtin_pkg::times9_mod10(w9_src),
                                            gtin_pkg::times7_mod10(w7_src));

    always_comb
    begin
        count_next      = count_reg;
        even_sum_next   = even_sum_reg;
        odd_sum_next    = odd_sum_reg;
        bad_next        = bad_reg;
        out_status_next = gtin_pkg::STATUS_CHECKED;
        out_kind_next   = gtin_pkg::KIND_NONE;
        out_digit_next  = 4'd0;
        out_mis_next    = 1'b0;
        if (!in_last_reg)
        begin
            if (!is_digit)
                bad_next = 1'b1;
            else if (!count_reg[0])
                even_sum_next = gtin_pkg::add_mod10(even_sum_reg, digit);
            else
                odd_sum_next = gtin_pkg::add_mod10(odd_sum_reg, digit);
            if (count_reg != gtin_pkg::COUNT_MAX)
                count_next = count_reg + 5'd1;
        end
        else
        begin
            count_next    = 5'd0;
            even_sum_next = 4'd0;
            odd_sum_next  = 4'd0;
            bad_next      = 1'b0;
            if (len_kind == gtin_pkg::KIND_NONE)
                out_status_next = gtin_pkg::STATUS_BAD_LEN;
            else if (bad_reg)
                out_status_next = gtin_pkg::STATUS_BAD_CHAR;
            else
            begin
                out_kind_next  = len_kind;
                out_digit_next = expect_val;
                out_mis_next   = {gtin_pkg::ASCII_HIGH, expect_val} != in_code_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            count_reg     <= 5'd0;
            even_sum_reg  <= 4'd0;
            odd_sum_reg   <= 4'd0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (work_fire)
                in_valid_reg <= 1'b0;

            if (work_fire)
            begin
                count_reg    <= count_next;
                even_sum_reg <= even_sum_next;
                odd_sum_reg  <= odd_sum_next;
                bad_reg      <= bad_next;
            end

            if (work_fire && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_code_reg <= char_code;
            in_last_reg <= last_char;
        end
        if (work_fire && in_last_reg)
        begin
            out_status_reg <= out_status_next;
            out_kind_reg   <= out_kind_next;
            out_digit_reg  <= out_digit_next;
            out_mis_reg    <= out_mis_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign status         = out_status_reg;
    assign kind           = out_kind_reg;
    assign expected_digit = out_digit_reg;
    assign mismatch       = out_mis_reg;

    // A failed check carries no kind, digit or mismatch.
    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != gtin_pkg::STATUS_CHECKED) |->
        (out_kind_reg == gtin_pkg::KIND_NONE && out_digit_reg == 4'd0 && !out_mis_reg))
        else $error("failed check has nonzero result fields");

    // A passed check names a length kind and a decimal digit.
    a_pass_fields_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == gtin_pkg::STATUS_CHECKED) |->
        (out_kind_reg != gtin_pkg::KIND_NONE && out_digit_reg < 4'd10))
        else $error("passed check has no kind or a bad digit");

    // A check character always lands in the result register.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (work_fire && in_last_reg) |=> out_valid_reg)
        else $error("check character produced no result");

    // The running state is cleared after each number.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (work_fire && in_last_reg) |=>
        (count_reg == 5'd0 && even_sum_reg == 4'd0 && odd_sum_reg == 4'd0 && !bad_reg))
        else $error("state not cleared after a number");

    // Sums stay decimal.
    a_sums_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        (even_sum_reg < 4'd10) && (odd_sum_reg < 4'd10))
        else $error("running sum left the decimal range");

endmodule

FILE: tb/sv/gtin_result_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the result beat of each number and compares it with the block.
module gtin_result_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    input  logic       char_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    input  logic       result_valid,
    input  logic       result_stall,
    input  logic [1:0] status,
    input  logic [2:0] kind,
    input  logic [3:0] expected_digit,
    input  logic       mismatch,
    output int         fail_count,
    output int         outstanding
);

    typedef struct packed {
        gtin_pkg::status_t status;
        gtin_pkg::kind_t   kind;
        logic [3:0]        digit;
        logic              mismatch;
    } verdict_t;

    verdict_t   pending_verdicts[$];
    logic [4:0] body_count;
    logic [3:0] even_sum;
    logic [3:0] odd_sum;
    logic       bad_body;
    int         errors;

    // Folds one accepted character into the running sums; a check character closes
    // the number and queues the verdict the block must give for it.
    task automatic absorb_char(input logic [7:0] c, input logic is_last);
        logic [7:0] d;
        logic [5:0] total;
        int         wsum;
        verdict_t   v;
        if (!is_last)
        begin
            d = c ^ 8'h30;
            if (d >= 8'd10)
                bad_body = 1'b1;
            else if (!body_count[0])
                even_sum = 4'((int'(even_sum) + int'(d)) % 10);
            else
                odd_sum = 4'((int'(odd_sum) + int'(d)) % 10);
            if (body_count != 5'd31)
                body_count = body_count + 5'd1;
        end
        else
        begin
            total = {1'b0, body_count} + 6'd1;
            v = '0;
            case (total)
                6'd8:    v.kind = gtin_pkg::KIND_LEN8;
                6'd12:   v.kind = gtin_pkg::KIND_LEN12;
                6'd13:   v.kind = gtin_pkg::KIND_LEN13;
                6'd14:   v.kind = gtin_pkg::KIND_LEN14;
                6'd17:   v.kind = gtin_pkg::KIND_LEN17;
                6'd18:   v.kind = gtin_pkg::KIND_LEN18;
                default: v.kind = gtin_pkg::KIND_NONE;
            endcase
            // A saturated count no longer tells the true length.
            if (body_count == 5'd31)
                v.kind = gtin_pkg::KIND_NONE;
            if (v.kind == gtin_pkg::KIND_NONE)
                v.status = gtin_pkg::STATUS_BAD_LEN;
            else if (bad_body)
            begin
                v.status = gtin_pkg::STATUS_BAD_CHAR;
                v.kind   = gtin_pkg::KIND_NONE;
            end
            else
            begin
                v.status = gtin_pkg::STATUS_CHECKED;
                // Weight 9 goes to the positions an even distance from the check character.
                if (total[0])
                    wsum = 9 * int'(even_sum) + 7 * int'(odd_sum);
                else
                    wsum = 9 * int'(odd_sum) + 7 * int'(even_sum);
                v.digit    = 4'(wsum % 10);
                v.mismatch = ({4'h3, v.digit} != c);
            end
            pending_verdicts.push_back(v);
            body_count = '0;
            even_sum   = '0;
            odd_sum    = '0;
            bad_body   = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            pending_verdicts.delete();
            body_count = '0;
            even_sum   = '0;
            odd_sum    = '0;
            bad_body   = 1'b0;
            errors     = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (char_valid && !char_stall)
                absorb_char(char_code, last_char);
            if (result_valid && !result_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result beat arrived with no number pending");
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, status);
                        errors++;
                    end
                    if (kind !== want.kind)
                    begin
                        $error("kind expected %0d got %0d", want.kind, kind);
                        errors++;
                    end
                    if (expected_digit !== want.digit)
                    begin
                        $error("expected_digit expected %0d got %0d", want.digit,
                               expected_digit);
                        errors++;
                    end
                    if (mismatch !== want.mismatch)
                    begin
                        $error("mismatch expected %0d got %0d", want.mismatch, mismatch);
                        errors++;
                    end
                end
            end
            fail_count  <= errors;
            outstanding <= pending_verdicts.size();
        end
    end

endmodule

FILE: tb/sv/gtin_check_digit_checker_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the GTIN check-digit checker: clock, reset, number stimulus and verdict.
module gtin_check_digit_checker_top_tb;

    localparam int CLK_HALF    = 10;
    localparam int QUIET_LIMIT = 2000;
    localparam int BEAT_TARGET = 750;
    localparam int CALM_AFTER  = 620;
    localparam int LONG_HOLD   = 150;

    typedef enum int {
        NUM_GOOD,
        NUM_WRONG_CHECK,
        NUM_BAD_CHAR,
        NUM_NOISE
    } number_form_t;

    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_stall;
    logic [7:0] char_code;
    logic       last_char;
    logic       result_valid;
    logic       result_stall;
    logic [1:0] status;
    logic [2:0] kind;
    logic [3:0] expected_digit;
    logic       mismatch;

    int fail_count;
    int outstanding;
    int beats_sent   = 0;
    int quiet_cycles = 0;
    int fixed_lengths[6] = '{8, 12, 13, 14, 17, 18};
    bit gaps_on      = 1'b0;
    bit stalls_on    = 1'b0;
    bit long_hold    = 1'b0;

    gtin_check_digit_checker_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .char_code      (char_code),
        .last_char      (last_char),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .status         (status),
        .kind           (kind),
        .expected_digit (expected_digit),
        .mismatch       (mismatch)
    );

    gtin_result_checker result_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .char_code      (char_code),
        .last_char      (last_char),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .status         (status),
        .kind           (kind),
        .expected_digit (expected_digit),
        .mismatch       (mismatch),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [7:0] non_digit();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c >= 8'h30 && c <= 8'h39);
        return c;
    endfunction

    task automatic send_beat(input logic [7:0] c, input logic is_last);
        if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        last_char  <= is_last;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], i == s.len() - 1);
    endtask

    // Builds a number of len characters; the check digit is worked out the usual way,
    // weight 3 on the body digit next to the check character and alternating from there.
    task automatic send_number(input int len, input number_form_t form);
        logic [7:0] chars[$];
        int         weighted;
        int         check;
        int         spot;
        weighted = 0;
        if (form == NUM_BAD_CHAR && len < 2)
            form = NUM_GOOD;
        for (int i = 0; i < len - 1; i++)
            chars.push_back(8'h30 + 8'($urandom_range(0, 9)));
        for (int i = 0; i < len - 1; i++)
            weighted += (int'(chars[i]) - 48) * (((len - 1 - i) % 2 == 1) ? 3 : 1);
        check = (10 - weighted % 10) % 10;
        case (form)
            NUM_GOOD:
                chars.push_back(8'h30 + 8'(check));
            NUM_WRONG_CHECK:
                if ($urandom_range(0, 1) == 1)
                    chars.push_back(8'h30 + 8'((check + $urandom_range(1, 9)) % 10));
                else
                    chars.push_back(non_digit());
            NUM_BAD_CHAR:
            begin
                spot = $urandom_range(0, len - 2);
                chars[spot] = non_digit();
                chars.push_back(8'h30 + 8'(check));
            end
            default:
            begin
                chars.delete();
                for (int i = 0; i < len; i++)
                    chars.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        foreach (chars[i])
            send_beat(chars[i], i == chars.size() - 1);
    endtask

    task automatic wait_for_results();
        char_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Receiver side: random stall bursts, plus one long hold when the sender asks for it.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((char_valid && !char_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int           len;
        int           pick;
        number_form_t form;
        bit           late;
        clk          = 1'b0;
        rst_n        = 1'b0;
        char_valid   = 1'b0;
        char_code    = '0;
        last_char    = 1'b0;
        result_stall = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest and largest digits, a lone check character, non-digit bytes at both
        // ends of the byte range, and a non-digit inside an otherwise good body.
        send_text("00000000");
        send_text("99999995");
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h2F, 1'b1);
        send_text("0000:000");
        wait_for_results();

        // The receiver holds off while short numbers keep coming, so the block backs up.
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        long_hold = 1'b1;
        repeat (12)
            send_number(8, NUM_GOOD);
        wait_for_results();

        while (beats_sent < BEAT_TARGET)
        begin
            late      = beats_sent >= CALM_AFTER;
            gaps_on   = !late && $urandom_range(0, 3) != 0;
            stalls_on = !late && $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 99) < 75)
                len = fixed_lengths[$urandom_range(0, 5)];
            else
                len = $urandom_range(1, 40);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                form = NUM_GOOD;
            else if (pick < 70)
                form = NUM_WRONG_CHECK;
            else if (pick < 85)
                form = NUM_BAD_CHAR;
            else
                form = NUM_NOISE;
            send_number(len, form);
            if ($urandom_range(0, 14) == 0)
                wait_for_results();
        end

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        wait_for_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
